### hdl/dls_pkg.sv
// ----------------------------------------------------------------------------
// dls_pkg
// Shared constants, types and helpers for the delta list task scheduler.
// ----------------------------------------------------------------------------
package dls_pkg;

  // Sizing
  localparam int MAX_TASKS   = 16;
  localparam int TICK_BITS   = 16;
  localparam int MAX_RESULTS = 16;

  localparam int IDX_W  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int PTR_W  = $clog2(MAX_TASKS + 1);
  localparam int RES_W  = $clog2(MAX_RESULTS + 1);
  localparam int MS_W   = 20;
  localparam int ID_W   = 4;
  localparam int KIND_W = 2;

  // Divide by ten through a reciprocal multiply; exact for any 20-bit input
  localparam int MS_PER_TICK = 10;
  localparam int RECIP_SHIFT = 23;
  localparam int RECIP_W     = 20;
  localparam int RECIP       = ((1 << RECIP_SHIFT) + MS_PER_TICK - 1) / MS_PER_TICK;
  localparam int PROD_W      = MS_W + RECIP_W;
  localparam int Q_W         = PROD_W - RECIP_SHIFT;
  localparam int QX_W        = Q_W + TICK_BITS;

  typedef logic [TICK_BITS-1:0] tick_t;
  typedef logic [PTR_W-1:0]     ptr_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [PROD_W-1:0]    prod_t;
  typedef logic [RES_W-1:0]     res_cnt_t;

  // Pointer value marking end of list / empty list
  localparam ptr_t PTR_NONE = ptr_t'(MAX_TASKS);

  typedef enum logic [KIND_W-1:0] {
    EV_DUE   = 2'd0,
    EV_ADDED = 2'd1,
    EV_FULL  = 2'd2
  } event_kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ADD_P,
    S_ADD_D,
    S_ADD_W,
    S_T_RD,
    S_T_DEC,
    S_D_ISSUE,
    S_D_CMP,
    S_L_WALK,
    S_L_CMP,
    S_L_INS1,
    S_L_INS2,
    S_END
  } state_t;

  typedef enum logic {
    RD_HEAD = 1'b0,
    RD_CUR  = 1'b1
  } rd_sel_t;

  typedef enum logic {
    MUL_PERIOD = 1'b0,
    MUL_DELAY  = 1'b1
  } mul_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic     in_ready;
    mul_sel_t mul_sel;
    rd_sel_t  rd_sel;
    logic     clr_n;
    logic     per_load;
    logic     add_start;
    logic     set_full;
    logic     dec_head;
    logic     pop;
    logic     walk_step;
    logic     cap_cur_delta;
    logic     ins1;
    logic     ins2;
    logic     emit;
    logic     emit_last;
  } dls_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic accept;
    logic func;
    logic full;
    logic head_valid;
    logic cur_valid;
    logic delta_zero;
    logic walk_le;
    logic n_max;
    logic pend_valid;
    logic out_free;
  } dls_status_t;

  function automatic logic ptr_valid(input ptr_t p);
    return p < PTR_NONE;
  endfunction

  function automatic ptr_t ptr_clamp(input ptr_t p);
    return ptr_valid(p) ? p : PTR_NONE;
  endfunction

  function automatic idx_t to_idx(input ptr_t p);
    return p[IDX_W-1:0];
  endfunction

  function automatic logic [ID_W-1:0] to_task_id(input ptr_t p);
    logic [PTR_W+ID_W-1:0] x;
    x = {{ID_W{1'b0}}, p};
    return x[ID_W-1:0];
  endfunction

  // Quotient out of the reciprocal product, saturated to the tick range
  function automatic tick_t prod_to_ticks(input prod_t prod);
    logic [QX_W-1:0] q;
    logic [QX_W-1:0] lim;
    q   = QX_W'(prod[PROD_W-1:RECIP_SHIFT]);
    lim = QX_W'({TICK_BITS{1'b1}});
    return (q > lim) ? lim[TICK_BITS-1:0] : q[TICK_BITS-1:0];
  endfunction

endpackage

### hdl/dls_in_if.sv
// ----------------------------------------------------------------------------
// dls_in_if
// Input item channel: valid/ready handshake with add or tick payload.
// ----------------------------------------------------------------------------
interface dls_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [19:0] delay_ms;
  logic [19:0] period_ms;

  modport source (output valid, func, delay_ms, period_ms, input ready);
  modport sink   (input valid, func, delay_ms, period_ms, output ready);
endinterface

### hdl/dls_out_if.sv
// ----------------------------------------------------------------------------
// dls_out_if
// Result channel: valid/ready handshake with event payload.
// ----------------------------------------------------------------------------
interface dls_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [3:0] task_id;
  logic       last_of_run;

  modport source (output valid, event_kind, task_id, last_of_run, input ready);
  modport sink   (input valid, event_kind, task_id, last_of_run, output ready);
endinterface

### hdl/delta_list_task_scheduler.sv
// ----------------------------------------------------------------------------
// delta_list_task_scheduler
// Periodic task timer queue kept as a sorted delta list over a slot pool.
// ----------------------------------------------------------------------------
//  channel  dir  payload                               transfer
//  item     in   func, delay_ms, period_ms             valid && ready
//  result   out  event_kind, task_id, last_of_run      valid && ready
//
//  One item at a time: the next item is taken only after the current one is
//  done. An add walks the list one entry at a time and may stop ahead of an
//  entry; a rejected add does not walk. A tick on an empty list does nothing
//  more; else it decrements the head and, per due task, pops it and inserts it
//  again by the same walk. Walk speed is set by the single read port of the
//  slot memories used by the insertion walk.
//  rst (synchronous) empties the list and pool; slot memories are not cleared.
//  A stalled result stalls the sequencer only when the held result must move on: when the next is found or at run end.
// ----------------------------------------------------------------------------
module delta_list_task_scheduler (
  input  logic      clk,
  input  logic      rst,
  dls_in_if.sink    item,
  dls_out_if.source result
);

  dls_pkg::dls_cmd_t    cmd;
  dls_pkg::dls_status_t st;

  dls_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  dls_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result),
    .cmd    (cmd),
    .st     (st)
  );

endmodule

### hdl/dls_ctrl.sv
// ----------------------------------------------------------------------------
// dls_ctrl
// Sequencer for add, tick dispatch and sorted list insertion.
// ----------------------------------------------------------------------------
module dls_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  dls_pkg::dls_status_t st,
  output dls_pkg::dls_cmd_t    cmd
);

  dls_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dls_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      dls_pkg::S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (st.accept) begin
          state_next = dls_pkg::S_DECODE;
        end
      end

      dls_pkg::S_DECODE: begin
        cmd.clr_n   = 1'b1;
        cmd.mul_sel = dls_pkg::MUL_PERIOD;
        if (st.func) begin
          if (st.full) begin
            cmd.set_full = 1'b1;
            state_next   = dls_pkg::S_END;
          end else begin
            state_next = dls_pkg::S_ADD_P;
          end
        end else if (st.head_valid) begin
          state_next = dls_pkg::S_T_RD;
        end else begin
          state_next = dls_pkg::S_IDLE;
        end
      end

      // Period product lands in the multiplier register
      dls_pkg::S_ADD_P: begin
        cmd.mul_sel = dls_pkg::MUL_PERIOD;
        state_next  = dls_pkg::S_ADD_D;
      end

      dls_pkg::S_ADD_D: begin
        cmd.per_load = 1'b1;
        cmd.mul_sel  = dls_pkg::MUL_DELAY;
        state_next   = dls_pkg::S_ADD_W;
      end

      dls_pkg::S_ADD_W: begin
        cmd.add_start = 1'b1;
        state_next    = dls_pkg::S_L_WALK;
      end

      // Tick: read head, decrement it
      dls_pkg::S_T_RD: begin
        cmd.rd_sel = dls_pkg::RD_HEAD;
        state_next = dls_pkg::S_T_DEC;
      end

      dls_pkg::S_T_DEC: begin
        cmd.dec_head = 1'b1;
        state_next   = dls_pkg::S_D_ISSUE;
      end

      // Dispatch loop over due entries at the head
      dls_pkg::S_D_ISSUE: begin
        cmd.rd_sel = dls_pkg::RD_HEAD;
        if (st.n_max || !st.head_valid) begin
          state_next = dls_pkg::S_END;
        end else begin
          state_next = dls_pkg::S_D_CMP;
        end
      end

      dls_pkg::S_D_CMP: begin
        cmd.rd_sel = dls_pkg::RD_HEAD;
        if (!st.delta_zero) begin
          state_next = dls_pkg::S_END;
        end else if (!st.pend_valid || st.out_free) begin
          cmd.emit   = st.pend_valid;
          cmd.pop    = 1'b1;
          state_next = dls_pkg::S_L_WALK;
        end
      end

      // Insertion walk
      dls_pkg::S_L_WALK: begin
        cmd.rd_sel = dls_pkg::RD_CUR;
        if (st.cur_valid) begin
          state_next = dls_pkg::S_L_CMP;
        end else begin
          state_next = dls_pkg::S_L_INS1;
        end
      end

      dls_pkg::S_L_CMP: begin
        cmd.rd_sel = dls_pkg::RD_CUR;
        if (st.walk_le) begin
          cmd.walk_step = 1'b1;
          state_next    = dls_pkg::S_L_WALK;
        end else begin
          cmd.cap_cur_delta = 1'b1;
          state_next        = dls_pkg::S_L_INS1;
        end
      end

      dls_pkg::S_L_INS1: begin
        cmd.ins1   = 1'b1;
        state_next = dls_pkg::S_L_INS2;
      end

      dls_pkg::S_L_INS2: begin
        cmd.ins2 = 1'b1;
        if (st.func) begin
          state_next = dls_pkg::S_END;
        end else begin
          state_next = dls_pkg::S_D_ISSUE;
        end
      end

      // Flush the held result as last of the run
      dls_pkg::S_END: begin
        if (!st.pend_valid) begin
          state_next = dls_pkg::S_IDLE;
        end else if (st.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          state_next    = dls_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = dls_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### hdl/dls_datapath.sv
// ----------------------------------------------------------------------------
// dls_datapath
// Slot memories, list pointers, ms-to-tick multiplier and result register.
// ----------------------------------------------------------------------------
module dls_datapath (
  input  logic                 clk,
  input  logic                 rst,
  dls_in_if.sink               item,
  dls_out_if.source            result,
  input  dls_pkg::dls_cmd_t    cmd,
  output dls_pkg::dls_status_t st
);

  // Slot memories
  dls_pkg::tick_t slot_delta     [dls_pkg::MAX_TASKS];
  dls_pkg::tick_t slot_period    [dls_pkg::MAX_TASKS];
  dls_pkg::ptr_t  slot_successor [dls_pkg::MAX_TASKS];

  dls_pkg::tick_t rd_delta;
  dls_pkg::tick_t rd_period;
  dls_pkg::ptr_t  rd_succ;
  dls_pkg::ptr_t  rd_ptr;

  // Captured item
  logic                        func;
  logic [dls_pkg::MS_W-1:0]    delay_ms;
  logic [dls_pkg::MS_W-1:0]    period_ms;

  // Conversion
  dls_pkg::prod_t              mult;
  logic [dls_pkg::MS_W-1:0]    mul_op;
  logic [dls_pkg::RECIP_W-1:0] recip;
  dls_pkg::tick_t              per_ticks;
  dls_pkg::tick_t              per_conv;

  // List walk
  dls_pkg::tick_t              d;
  dls_pkg::tick_t              cur_delta;
  dls_pkg::ptr_t               id;
  dls_pkg::ptr_t               cur;
  dls_pkg::ptr_t               prev;
  dls_pkg::ptr_t               head;
  dls_pkg::ptr_t               tasks_added;
  dls_pkg::res_cnt_t           n;

  // Held result
  logic                        pend_valid;
  dls_pkg::event_kind_t        pend_kind;
  dls_pkg::ptr_t               pend_id;

  // Output register
  logic                        out_valid;
  dls_pkg::event_kind_t        out_kind;
  logic [dls_pkg::ID_W-1:0]    out_id;
  logic                        out_last;

  // Write ports
  logic                        dw_en;
  dls_pkg::idx_t               dw_addr;
  dls_pkg::tick_t              dw_data;
  logic                        sw_en;
  dls_pkg::idx_t               sw_addr;
  dls_pkg::ptr_t               sw_data;

  logic                        accept;

  // No input transfer while in reset
  assign item.ready = cmd.in_ready && !rst;
  assign accept     = item.valid && item.ready;

  // Item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      func      <= item.func;
      delay_ms  <= item.delay_ms;
      period_ms <= item.period_ms;
    end
  end

  // Reciprocal multiply, registered
  assign recip  = dls_pkg::RECIP_W'(dls_pkg::RECIP);
  assign mul_op = (cmd.mul_sel == dls_pkg::MUL_DELAY) ? delay_ms : period_ms;

  always_ff @(posedge clk) begin
    mult <= {{dls_pkg::RECIP_W{1'b0}}, mul_op} * {{dls_pkg::MS_W{1'b0}}, recip};
  end

  assign per_conv = dls_pkg::prod_to_ticks(mult);

  always_ff @(posedge clk) begin
    if (cmd.per_load) begin
      per_ticks <= (per_conv == '0) ? dls_pkg::tick_t'(1) : per_conv;
    end
  end

  // Memory read, one address per cycle
  assign rd_ptr = (cmd.rd_sel == dls_pkg::RD_HEAD) ? head : cur;

  always_ff @(posedge clk) begin
    rd_delta  <= slot_delta[dls_pkg::to_idx(rd_ptr)];
    rd_period <= slot_period[dls_pkg::to_idx(rd_ptr)];
    rd_succ   <= slot_successor[dls_pkg::to_idx(rd_ptr)];
  end

  // Delta write port select
  always_comb begin
    dw_en   = 1'b0;
    dw_addr = dls_pkg::to_idx(id);
    dw_data = d;
    if (cmd.ins1) begin
      dw_en = 1'b1;
    end else if (cmd.ins2 && dls_pkg::ptr_valid(cur)) begin
      dw_en   = 1'b1;
      dw_addr = dls_pkg::to_idx(cur);
      dw_data = cur_delta - d;
    end else if (cmd.dec_head && (rd_delta != '0)) begin
      dw_en   = 1'b1;
      dw_addr = dls_pkg::to_idx(head);
      dw_data = rd_delta - dls_pkg::tick_t'(1);
    end
  end

  // Successor write port select
  always_comb begin
    sw_en   = 1'b0;
    sw_addr = dls_pkg::to_idx(id);
    sw_data = cur;
    if (cmd.ins1) begin
      sw_en = 1'b1;
    end else if (cmd.ins2 && dls_pkg::ptr_valid(prev)) begin
      sw_en   = 1'b1;
      sw_addr = dls_pkg::to_idx(prev);
      sw_data = id;
    end
  end

  // Memory writes
  always_ff @(posedge clk) begin
    if (dw_en) begin
      slot_delta[dw_addr] <= dw_data;
    end
    if (sw_en) begin
      slot_successor[sw_addr] <= sw_data;
    end
    if (cmd.add_start) begin
      slot_period[dls_pkg::to_idx(tasks_added)] <= per_ticks;
    end
  end

  // Walk registers
  always_ff @(posedge clk) begin
    if (cmd.add_start) begin
      d    <= per_conv;
      id   <= tasks_added;
      cur  <= head;
      prev <= dls_pkg::PTR_NONE;
    end else if (cmd.pop) begin
      d    <= rd_period;
      id   <= head;
      cur  <= dls_pkg::ptr_clamp(rd_succ);
      prev <= dls_pkg::PTR_NONE;
    end else if (cmd.walk_step) begin
      d    <= d - rd_delta;
      prev <= cur;
      cur  <= dls_pkg::ptr_clamp(rd_succ);
    end
    if (cmd.cap_cur_delta) begin
      cur_delta <= rd_delta;
    end
  end

  // List head, pool fill and run count
  always_ff @(posedge clk) begin
    if (rst) begin
      head        <= dls_pkg::PTR_NONE;
      tasks_added <= '0;
      n           <= '0;
    end else begin
      if (cmd.pop) begin
        head <= dls_pkg::ptr_clamp(rd_succ);
      end else if (cmd.ins2 && !dls_pkg::ptr_valid(prev)) begin
        head <= id;
      end
      if (cmd.add_start) begin
        tasks_added <= tasks_added + dls_pkg::ptr_t'(1);
      end
      if (cmd.clr_n) begin
        n <= '0;
      end else if (cmd.pop) begin
        n <= n + dls_pkg::res_cnt_t'(1);
      end
    end
  end

  // Held result: flushed when the next one is found or at run end
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else begin
      if (cmd.emit_last) begin
        pend_valid <= 1'b0;
      end
      if (cmd.pop || cmd.add_start || cmd.set_full) begin
        pend_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      pend_kind <= dls_pkg::EV_DUE;
      pend_id   <= head;
    end else if (cmd.add_start) begin
      pend_kind <= dls_pkg::EV_ADDED;
      pend_id   <= tasks_added;
    end else if (cmd.set_full) begin
      pend_kind <= dls_pkg::EV_FULL;
      pend_id   <= '0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind <= pend_kind;
      out_id   <= dls_pkg::to_task_id(pend_id);
      out_last <= cmd.emit_last;
    end
  end

  assign result.valid       = out_valid;
  assign result.event_kind  = out_kind;
  assign result.task_id     = out_id;
  assign result.last_of_run = out_last;

  // Status
  always_comb begin
    st            = '0;
    st.accept     = accept;
    st.func       = func;
    st.full       = (tasks_added == dls_pkg::ptr_t'(dls_pkg::MAX_TASKS));
    st.head_valid = dls_pkg::ptr_valid(head);
    st.cur_valid  = dls_pkg::ptr_valid(cur);
    st.delta_zero = (rd_delta == '0);
    st.walk_le    = (rd_delta <= d);
    st.n_max      = (n == dls_pkg::res_cnt_t'(dls_pkg::MAX_RESULTS));
    st.pend_valid = pend_valid;
    st.out_free   = !out_valid || result.ready;
  end

endmodule

### hdl/dls_checker.sv
// ----------------------------------------------------------------------------
// dls_checker
// Port-level checks on the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module dls_checker (
  input logic       clk,
  input logic       rst,
  input logic       item_valid,
  input logic       item_ready,
  input logic       result_valid,
  input logic       result_ready,
  input logic [1:0] event_kind,
  input logic [3:0] task_id,
  input logic       last_of_run
);

  // Add outcomes are always a run of one
  a_add_single: assert property (@(posedge clk) disable iff (rst)
    result_valid && (event_kind == dls_pkg::EV_ADDED || event_kind == dls_pkg::EV_FULL)
    |-> last_of_run)
    else $error("add result not marked last of run");

  // Rejected add reports slot zero
  a_full_id: assert property (@(posedge clk) disable iff (rst)
    result_valid && (event_kind == dls_pkg::EV_FULL) |-> (task_id == 4'd0))
    else $error("rejected add with nonzero task id");

  // One item in flight: no back-to-back transfers on the input
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("input ready right after a transfer");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(event_kind)
    && $stable(task_id) && $stable(last_of_run))
    else $error("stalled result changed");

endmodule

bind delta_list_task_scheduler dls_checker u_dls_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .event_kind   (result.event_kind),
  .task_id      (result.task_id),
  .last_of_run  (result.last_of_run)
);
